/* hw/rtl/edf_pkg.sv */
// Package for the EDF partition scheduler: sizes, command codes and the
// transfer and memory-entry structs. Used by every RTL file of the block.
package edf_pkg;

    localparam int MAX_SLOTS = 8;
    localparam int TIME_BITS = 16;
    localparam int SLOT_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    localparam logic [0:0] CMD_LOAD = 1'b0;
    localparam logic [0:0] CMD_TICK = 1'b1;

    localparam logic [3:0] ACTIVE_RESET = 4'd8;

    typedef struct packed {
        logic [0:0]  command;
        logic [2:0]  slot;
        logic [15:0] budget;
        logic [15:0] period_len;
    } t_in;

    typedef struct packed {
        logic       idle;
        logic [2:0] chosen;
        logic [7:0] miss_mask;
    } t_out;

    typedef struct packed {
        logic [TIME_BITS-1:0] budget_table;
        logic [TIME_BITS-1:0] period_table;
        logic [TIME_BITS-1:0] budget_left;
        logic [TIME_BITS-1:0] deadline_left;
        logic [TIME_BITS-1:0] phase_count;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_entry            data;
    } t_wr_req;

endpackage

/* hw/rtl/edf_partition_scheduler.sv */
// Top level of the EDF partition scheduler: configuration register, load path
// and write-port arbitration. Uses edf_pkg, edf_slot_ram and edf_tick_seq.
//
// Usage: an item on i_cmd is taken at a rising edge with start high and busy
// low. A load (command 0) writes one slot in that same cycle and leaves busy
// low, so a new item can follow in the next cycle; it gives no result.
// A tick (command 1) raises busy while the sequencer makes two passes over
// the slot memory, a selection scan and then an update scan over n slots,
// n = min(active_slots, 8); the memory port serves one slot per cycle. The
// result is on o_res with o_res_valid high for exactly one cycle, once the
// update scan ends (the cycle after the accepting edge if no slot is active);
// busy is low in that cycle, so the next item may be accepted there. The
// receiver cannot hold a result off.
// The configuration channel (i_cfg_valid, o_cfg_ready, always ready) writes
// active_slots; write it only while no tick is in flight.
// Reset (synchronous, active low) sets active_slots to 8 and makes every slot
// read as all zero until it is loaded or written back by a tick.
module edf_partition_scheduler (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  edf_pkg::t_in  i_cmd,
    output logic          o_res_valid,
    output edf_pkg::t_out o_res,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [3:0]    i_cfg_data
);

    logic [3:0]                r_active;
    logic [edf_pkg::CNT_W-1:0] n_act;
    logic                      seq_busy;
    logic                      accept;
    logic                      load_en;
    logic                      tick_go;
    edf_pkg::t_rd_req          rd_req;
    edf_pkg::t_wr_req          seq_wr;
    edf_pkg::t_wr_req          ram_wr;
    edf_pkg::t_entry           rd_data;
    edf_pkg::t_entry           load_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= edf_pkg::ACTIVE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_active <= i_cfg_data;
        end
    end

    assign n_act = (32'(r_active) > edf_pkg::MAX_SLOTS)
                 ? edf_pkg::CNT_W'(edf_pkg::MAX_SLOTS)
                 : edf_pkg::CNT_W'(r_active);

    assign accept  = start && !seq_busy;
    assign load_en = accept && (i_cmd.command == edf_pkg::CMD_LOAD)
                   && (32'(i_cmd.slot) < edf_pkg::MAX_SLOTS);
    assign tick_go = accept && (i_cmd.command == edf_pkg::CMD_TICK);

    always_comb begin
        load_entry.budget_table  = edf_pkg::TIME_BITS'(i_cmd.budget);
        load_entry.period_table  = edf_pkg::TIME_BITS'(i_cmd.period_len);
        load_entry.budget_left   = edf_pkg::TIME_BITS'(i_cmd.budget);
        load_entry.deadline_left = edf_pkg::TIME_BITS'(i_cmd.period_len);
        load_entry.phase_count   = '0;
        if (load_en) begin
            ram_wr.en   = 1'b1;
            ram_wr.addr = edf_pkg::SLOT_W'(i_cmd.slot);
            ram_wr.data = load_entry;
        end else begin
            ram_wr = seq_wr;
        end
    end

    edf_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rd_req),
        .i_wr      (ram_wr),
        .o_rd_data (rd_data)
    );

    edf_tick_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_go      (tick_go),
        .i_n_act   (n_act),
        .i_rd_data (rd_data),
        .o_busy    (seq_busy),
        .o_rd      (rd_req),
        .o_wr      (seq_wr),
        .o_done    (o_res_valid),
        .o_res     (o_res)
    );

    assign busy = seq_busy;

endmodule

/* hw/rtl/edf_slot_ram.sv */
// Slot state memory: one entry per partition slot, data out the cycle after a read.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses edf_pkg.
module edf_slot_ram (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  edf_pkg::t_rd_req i_rd,
    input  edf_pkg::t_wr_req i_wr,
    output edf_pkg::t_entry  o_rd_data
);

    edf_pkg::t_entry               mem [edf_pkg::MAX_SLOTS];
    logic [edf_pkg::MAX_SLOTS-1:0] r_vld;
    edf_pkg::t_entry               r_rd_data;
    logic                          r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_vld <= r_vld[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

/* hw/rtl/edf_tick_seq.sv */
// Tick sequencer: a selection scan over the slot memory, then an update scan
// that writes each slot back, and the registered result. Uses edf_pkg.
module edf_tick_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_go,
    input  logic [edf_pkg::CNT_W-1:0]  i_n_act,
    input  edf_pkg::t_entry            i_rd_data,
    output logic                       o_busy,
    output edf_pkg::t_rd_req           o_rd,
    output edf_pkg::t_wr_req           o_wr,
    output logic                       o_done,
    output edf_pkg::t_out              o_res
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SEL  = 3'b010,
        S_UPD  = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [edf_pkg::CNT_W-1:0]       r_idx, n_idx;
    logic                            r_pend, n_pend;
    logic [edf_pkg::SLOT_W-1:0]      r_pidx, n_pidx;
    logic                            r_found, n_found;
    logic [edf_pkg::SLOT_W-1:0]      r_best, n_best;
    logic [edf_pkg::TIME_BITS-1:0]   r_best_ddl, n_best_ddl;
    logic [7:0]                      r_miss, n_miss;
    logic                            r_done, n_done;
    edf_pkg::t_out                   r_res, n_res;

    logic                            issue;
    logic                            spend;
    logic [edf_pkg::TIME_BITS-1:0]   bl_eff;
    logic [edf_pkg::TIME_BITS-1:0]   last_tick;
    logic                            at_end;
    logic                            miss_hit;
    logic [31:0]                     best_ext;
    edf_pkg::t_entry                 upd;

    assign issue = (r_state != S_IDLE) && (r_idx < i_n_act);

    always_comb begin
        spend     = r_found && (r_pidx == r_best);
        bl_eff    = spend ? i_rd_data.budget_left - edf_pkg::TIME_BITS'(1)
                          : i_rd_data.budget_left;
        last_tick = i_rd_data.period_table - edf_pkg::TIME_BITS'(1);
        at_end    = i_rd_data.phase_count == last_tick;
        miss_hit  = at_end && (bl_eff != '0);
        upd       = i_rd_data;
        if (at_end) begin
            upd.budget_left   = i_rd_data.budget_table;
            upd.deadline_left = i_rd_data.period_table;
            upd.phase_count   = '0;
        end else begin
            upd.budget_left   = bl_eff;
            upd.deadline_left = (i_rd_data.deadline_left != '0)
                              ? i_rd_data.deadline_left - edf_pkg::TIME_BITS'(1)
                              : i_rd_data.deadline_left;
            upd.phase_count   = i_rd_data.phase_count + edf_pkg::TIME_BITS'(1);
        end
    end

    always_comb begin
        o_rd.en   = issue;
        o_rd.addr = r_idx[edf_pkg::SLOT_W-1:0];
        o_wr.en   = (r_state == S_UPD) && r_pend;
        o_wr.addr = r_pidx;
        o_wr.data = upd;
    end

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        n_found    = r_found;
        n_best     = r_best;
        n_best_ddl = r_best_ddl;
        n_miss     = r_miss;
        n_done     = 1'b0;
        n_res      = r_res;
        best_ext   = 32'(r_best);

        if (issue) begin
            n_idx  = r_idx + edf_pkg::CNT_W'(1);
            n_pend = 1'b1;
            n_pidx = r_idx[edf_pkg::SLOT_W-1:0];
        end else begin
            n_pend = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_go) begin
                    n_found = 1'b0;
                    n_miss  = '0;
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    if (i_n_act == '0) begin
                        n_done = 1'b1;
                        n_res  = '{idle: 1'b1, chosen: 3'd0, miss_mask: 8'd0};
                    end else begin
                        n_state = S_SEL;
                    end
                end
            end
            S_SEL: begin
                if (r_pend && (i_rd_data.budget_left != '0)
                        && (!r_found || (i_rd_data.deadline_left <= r_best_ddl))) begin
                    n_found    = 1'b1;
                    n_best     = r_pidx;
                    n_best_ddl = i_rd_data.deadline_left;
                end
                if (r_pend && !issue) begin
                    n_state = S_UPD;
                    n_idx   = '0;
                end
            end
            S_UPD: begin
                for (int b = 0; b < 8; b++) begin
                    if (r_pend && miss_hit && (int'(r_pidx) == b)) begin
                        n_miss[b] = 1'b1;
                    end
                end
                if (r_pend && !issue) begin
                    n_state = S_IDLE;
                    n_done  = 1'b1;
                    n_res   = '{idle: !r_found,
                                chosen: r_found ? best_ext[2:0] : 3'd0,
                                miss_mask: n_miss};
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_found <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
            r_found <= n_found;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx     <= n_pidx;
        r_best     <= n_best;
        r_best_ddl <= n_best_ddl;
        r_miss     <= n_miss;
        r_res      <= n_res;
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_done;
    assign o_res  = r_res;

    a_no_rw_same_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_wr.en && o_rd.en) |-> (o_wr.addr != o_rd.addr))
        else $error("read and write-back hit the same slot entry");

    a_no_read_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!o_rd.en && !o_wr.en))
        else $error("memory access while the sequencer is idle");

    a_done_after_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (r_state == S_IDLE) && !$past(r_state == S_SEL))
        else $error("result strobe outside the end of a tick");

    a_idle_chosen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.idle) |-> (o_res.chosen == 3'd0))
        else $error("idle result names a slot");

endmodule
